// ===== hw/rtl/trng_pkg.sv =====
// trng_pkg: shared types and constants of the trivium random generator
// used by the controller, the datapath, the divider and the top level
// no dependencies
`default_nettype none

package trng_pkg;

  localparam int StateBits  = 288;
  localparam int WordBits   = 32;
  localparam int ByteBits   = 8;
  localparam int WarmSteps  = 4 * StateBits;
  localparam int WarmCycles = WarmSteps / WordBits;
  localparam int WarmCntW   = $clog2(WarmCycles);
  localparam int CountW     = 7;
  localparam int MaxBytes   = 64;
  localparam int DivCntW    = $clog2(WordBits);
  localparam int SeedCntW   = 16;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_WORD   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_BYTES  = 2'd3
  } trng_op_e;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_IFACE_ID = 2'd2,
    REG_ENTROPY  = 2'd3
  } trng_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_WORD,
    ST_RANGE,
    ST_DIV,
    ST_BYTE,
    ST_EMIT
  } trng_state_e;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_WORD,
    SEL_LOW,
    SEL_RANGE,
    SEL_BYTE
  } trng_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      load_seed;
    logic      adv_word;
    logic      adv_byte;
    logic      div_start;
    logic      emit;
    logic      emit_last;
    trng_sel_e emit_sel;
  } trng_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic range_trivial;
    logic span_zero;
    logic div_busy;
  } trng_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trng_divider.sv =====
// trng_divider: restoring remainder unit, one quotient bit per cycle
// depends on trng_pkg
`default_nettype none

module trng_divider
  import trng_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [WordBits-1:0] dividend_i,
  input  wire logic [WordBits-1:0] divisor_i,
  output logic                     busy_o,
  output logic [WordBits-1:0]      rem_o
);

  logic                busy_q, busy_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [WordBits-1:0] num_q, num_d;
  logic [WordBits-1:0] den_q, den_d;
  logic [WordBits-1:0] rem_q, rem_d;
  logic [WordBits:0]   rem_sh;
  logic [WordBits:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, num_q[WordBits-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[WordBits-2:0], 1'b0};
      // for a nonzero divisor the remainder stays below the divisor, so it fits the word
      rem_d = rem_sub[WordBits] ? rem_sh[WordBits-1:0] : rem_sub[WordBits-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(WordBits - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/trng_datapath.sv =====
// trng_datapath: cipher state, 32-step or 8-step unrolled update, seed load,
// range arithmetic and output register; depends on trng_pkg, trng_divider
`default_nettype none

module trng_datapath
  import trng_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire trng_cmd_t           cmd_i,
  output trng_stat_t               stat_o,
  input  wire logic [63:0]         key_low_i,
  input  wire logic [15:0]         key_high_i,
  input  wire logic [63:0]         iface_id_i,
  input  wire logic [WordBits-1:0] entropy_i,
  input  wire logic [WordBits-1:0] range_low_i,
  input  wire logic [WordBits-1:0] range_high_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [WordBits-1:0]      out_value_o,
  output logic                     out_last_o
);

  // s(n) lives in bit n-1
  logic [StateBits-1:0] st_q, st_d;
  logic [SeedCntW-1:0]  seed_cnt_q, seed_cnt_d;
  logic [WordBits-1:0]  word_q;
  logic [WordBits-1:0]  low_q, high_q;
  logic                 out_valid_q;
  logic [WordBits-1:0]  out_value_q;
  logic                 out_last_q;

  logic [WordBits-1:0]  z, t1, t2, t3;
  logic [WordBits-1:0]  word_now;
  logic [WordBits-1:0]  span;
  logic [WordBits-1:0]  rem;
  logic                 div_busy;
  logic [WordBits-1:0]  emit_value;

  function automatic logic [StateBits-1:0] seed_state(
    input logic [63:0]         key_lo,
    input logic [15:0]         key_hi,
    input logic [63:0]         iface,
    input logic [SeedCntW-1:0] cnt
  );
    logic [StateBits-1:0] s;
    s = '0;
    s[63:0]  = key_lo;
    s[79:64] = key_hi;
    // iv bytes 0..7 are the identifier, most significant byte first
    for (int i = 0; i < 8; i++) begin
      s[93 + 8*i +: 8] = iface[56 - 8*i +: 8];
    end
    s[157 +: 8] = cnt[15:8];
    s[165 +: 8] = cnt[7:0];
    s[287:285]  = 3'b111;
    return s;
  endfunction

  // k steps at once; feedback taps sit far enough back for k up to 32
  function automatic logic [StateBits-1:0] shift_state(
    input logic [StateBits-1:0] s,
    input logic [WordBits-1:0]  f1,
    input logic [WordBits-1:0]  f2,
    input logic [WordBits-1:0]  f3,
    input int                   k
  );
    logic [StateBits-1:0] r;
    r = s;
    for (int n = 0; n < 93; n++) begin
      if (n < k) r[n] = f3[k-1-n];
      else       r[n] = s[n-k];
    end
    for (int n = 93; n < 177; n++) begin
      if (n - 93 < k) r[n] = f1[k-1-(n-93)];
      else            r[n] = s[n-k];
    end
    for (int n = 177; n < StateBits; n++) begin
      if (n - 177 < k) r[n] = f2[k-1-(n-177)];
      else             r[n] = s[n-k];
    end
    return r;
  endfunction

  // taps of 32 consecutive steps, all taken from the current state
  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      z[i]  = st_q[65-i] ^ st_q[92-i] ^ st_q[161-i] ^ st_q[176-i]
            ^ st_q[242-i] ^ st_q[287-i];
      t1[i] = st_q[65-i] ^ st_q[92-i] ^ (st_q[90-i] & st_q[91-i]) ^ st_q[170-i];
      t2[i] = st_q[161-i] ^ st_q[176-i] ^ (st_q[174-i] & st_q[175-i]) ^ st_q[263-i];
      t3[i] = st_q[242-i] ^ st_q[287-i] ^ (st_q[285-i] & st_q[286-i]) ^ st_q[68-i];
    end
  end

  assign word_now = z + entropy_i;
  assign span     = high_q - low_q + 1'b1;

  always_comb begin
    st_d       = st_q;
    seed_cnt_d = seed_cnt_q;
    if (cmd_i.load_seed) begin
      seed_cnt_d = seed_cnt_q + 1'b1;
      st_d       = seed_state(key_low_i, key_high_i, iface_id_i, seed_cnt_d);
    end else if (cmd_i.adv_word) begin
      st_d = shift_state(st_q, t1, t2, t3, WordBits);
    end else if (cmd_i.adv_byte) begin
      st_d = shift_state(st_q, t1, t2, t3, ByteBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      seed_cnt_q <= '0;
    end else begin
      st_q       <= st_d;
      seed_cnt_q <= seed_cnt_d;
    end
  end

  // low byte of the sum only depends on the low bytes, so bytes reuse it
  always_ff @(posedge clk_i) begin
    if (cmd_i.adv_word || cmd_i.adv_byte) begin
      word_q <= word_now;
    end
    if (cmd_i.capture) begin
      low_q  <= range_low_i;
      high_q <= range_high_i;
    end
  end

  trng_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (word_now),
    .divisor_i  (span),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  always_comb begin
    case (cmd_i.emit_sel)
      SEL_ZERO:  emit_value = '0;
      SEL_WORD:  emit_value = word_q;
      SEL_LOW:   emit_value = low_q;
      SEL_RANGE: emit_value = low_q + rem;
      SEL_BYTE:  emit_value = {{(WordBits-ByteBits){1'b0}}, word_q[ByteBits-1:0]};
      default:   emit_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= emit_value;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign stat_o.out_free      = !out_valid_q || out_ready_i;
  assign stat_o.range_trivial = !(high_q > low_q);
  assign stat_o.span_zero     = (span == '0);
  assign stat_o.div_busy      = div_busy;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/trng_ctrl.sv =====
// trng_ctrl: command sequencer for the random generator
// depends on trng_pkg
`default_nettype none

module trng_ctrl
  import trng_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire trng_op_e          op_i,
  input  wire logic [CountW-1:0] byte_count_i,
  input  wire trng_stat_t        stat_i,
  output trng_cmd_t              cmd_o
);

  trng_state_e           state_q, state_d;
  trng_op_e              op_q, op_d;
  trng_sel_e             sel_q, sel_d;
  logic [WarmCntW-1:0]   warm_q, warm_d;
  logic [CountW-1:0]     left_q, left_d;
  logic [CountW-1:0]     count_sat;

  assign count_sat = (byte_count_i > CountW'(MaxBytes)) ? CountW'(MaxBytes) : byte_count_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    sel_d   = sel_q;
    warm_d  = warm_q;
    left_d  = left_q;
    cmd_o   = '0;
    cmd_o.emit_sel = sel_q;
    in_ready_o     = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          op_d          = op_i;
          unique case (op_i)
            OP_RESEED: begin
              cmd_o.load_seed = 1'b1;
              warm_d          = '0;
              state_d         = ST_WARM;
            end
            OP_WORD:  state_d = ST_WORD;
            OP_RANGE: state_d = ST_RANGE;
            OP_BYTES: begin
              left_d = count_sat;
              if (count_sat != '0) begin
                state_d = ST_BYTE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WARM: begin
        cmd_o.adv_word = 1'b1;
        warm_d         = warm_q + 1'b1;
        if (warm_q == WarmCntW'(WarmCycles - 1)) begin
          sel_d   = SEL_ZERO;
          state_d = ST_EMIT;
        end
      end
      ST_WORD: begin
        cmd_o.adv_word = 1'b1;
        sel_d          = SEL_WORD;
        state_d        = ST_EMIT;
      end
      ST_RANGE: begin
        if (stat_i.range_trivial) begin
          sel_d   = SEL_LOW;
          state_d = ST_EMIT;
        end else begin
          cmd_o.adv_word = 1'b1;
          if (stat_i.span_zero) begin
            sel_d   = SEL_WORD;
            state_d = ST_EMIT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          sel_d   = SEL_RANGE;
          state_d = ST_EMIT;
        end
      end
      ST_BYTE: begin
        cmd_o.adv_byte = 1'b1;
        sel_d          = SEL_BYTE;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = (op_q != OP_BYTES) || (left_q == CountW'(1));
          if ((op_q == OP_BYTES) && (left_q != CountW'(1))) begin
            left_d  = left_q - 1'b1;
            state_d = ST_BYTE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_RESEED;
      sel_q   <= SEL_ZERO;
      warm_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      sel_q   <= sel_d;
      warm_q  <= warm_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trivium_random_generator.sv =====
// trivium_random_generator: top level with register file and stream ports
// depends on trng_pkg, trng_ctrl, trng_datapath (with trng_divider)
`default_nettype none

// Trivium keystream generator with a 288-bit state. One command beat comes
// in on the slave stream (tuser = command, tdata = range bounds and byte
// count); result beats leave on the master stream, tlast marking the final
// beat of each command. When stepped, the state advances 32 cipher steps
// per cycle through an unrolled update, or 8 steps for a byte. A reseed
// loads the seed, runs the warm-up in 32-step advances, then sends the
// zero acknowledge beat; a word advances and sends the word; a range that
// needs no division sends the low bound or the word, else waits for the
// one-bit-per-cycle remainder unit; each byte is one advance and beat. A
// new command is taken once the previous one has put its last beat into the
// output register, even while that beat still waits for tready. Registers
// sit on the APB port at 8-byte steps and should only be written while idle.

module trivium_random_generator
  import trng_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // range_low[31:0], range_high[63:32],
                                          // byte_count[70:64], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // random_value[31:0]
  output logic             m_axis_tlast   // last
);

  logic [63:0]         key_low_q;
  logic [15:0]         key_high_q;
  logic [63:0]         iface_id_q;
  logic [WordBits-1:0] entropy_q;
  trng_reg_e           reg_idx;
  logic                wr_en;

  trng_cmd_t           cmd;
  trng_stat_t          stat;

  // register file, one 64-bit slot per register
  assign pready  = 1'b1;
  assign reg_idx = trng_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      iface_id_q <= '0;
      entropy_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata[15:0];
        REG_IFACE_ID: iface_id_q <= pwdata;
        REG_ENTROPY:  entropy_q  <= pwdata[WordBits-1:0];
        default:      key_low_q  <= key_low_q;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = {48'd0, key_high_q};
      REG_IFACE_ID: prdata = iface_id_q;
      REG_ENTROPY:  prdata = {32'd0, entropy_q};
      default:      prdata = '0;
    endcase
  end

  // sequencer
  trng_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (trng_op_e'(s_axis_tuser)),
    .byte_count_i (s_axis_tdata[70:64]),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // cipher, range arithmetic and output beat register
  trng_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_low_i    (key_low_q),
    .key_high_i   (key_high_q),
    .iface_id_i   (iface_id_q),
    .entropy_i    (entropy_q),
    .range_low_i  (s_axis_tdata[31:0]),
    .range_high_i (s_axis_tdata[63:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire
